@@ sv/assert_macros.svh @@
// Assertion helpers for the comment stripper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on clk with active-low reset rst_n.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same, with the default clock and reset names of this project.
`define ASSERT_STD(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

@@ sv/jcs_pkg.sv @@
// ----------------------------------------------------------------------------
// jcs_pkg
// Types and byte codes of the JSON comment stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package jcs_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Result buffer depth and its index/count widths.
  localparam int unsigned BUF_DEPTH = 4;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
  localparam int unsigned BUF_CW    = $clog2(BUF_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_STR        = 3'd1,
    MODE_STR_ESC    = 3'd2,
    MODE_SLASH      = 3'd3,
    MODE_LINE       = 3'd4,
    MODE_BLOCK      = 3'd5,
    MODE_BLOCK_STAR = 3'd6
  } mode_e;

  typedef struct packed {
    logic       last;
    logic [7:0] ch;
  } res_t;

endpackage

`default_nettype wire

@@ sv/json_comment_stripper_unit.sv @@
// ----------------------------------------------------------------------------
// json_comment_stripper_unit
// Removes line and block comments from a JSON text streamed one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries the text: tdata = byte, tlast = last byte of
//   the text. Master channel m_axis carries the stripped text: tdata = byte,
//   tlast = final result produced by one input byte.
//   An input item lands in an input register; once the result buffer has
//   room, a small decode of the scan mode and that byte writes zero, one or
//   two results into a four-entry result buffer that drives m_axis.
//   Throughput is one input item per cycle while the result buffer has room.
//   An input byte that releases a held slash yields two results, and the
//   result buffer port reads one result per cycle.
//   When the receiver stalls the buffer fills; the input register stops
//   draining once more than two results wait, and s_axis_tready drops.
//   Reset empties the input register and result buffer and puts the scanner
//   in normal text mode. An item marked tlast returns it to normal mode too.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module json_comment_stripper_unit
  import jcs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  wire logic       s_axis_tlast,   // is_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] char_out
  output logic            m_axis_tlast    // run_last
);

  // Input register
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_char_q;
  logic        in_last_q;

  mode_e       mode_q, mode_d;

  // Result buffer
  res_t              buf_q [BUF_DEPTH];
  logic [BUF_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [BUF_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [BUF_CW-1:0] cnt_q, cnt_d;

  logic        fire;
  logic        pop;
  logic [1:0]  n_res;
  logic [7:0]  r0_ch, r1_ch;
  mode_e       mode_nx;

  // Process the held item only when the buffer can take two results.
  assign fire          = in_valid_q && (cnt_q <= BUF_CW'(BUF_DEPTH - 2));
  assign s_axis_tready = !in_valid_q || fire;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !fire);

  assign m_axis_tvalid = (cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = buf_q[rd_ptr_q].ch;
  assign m_axis_tlast  = buf_q[rd_ptr_q].last;

  always_comb begin
    n_res   = 2'd0;
    r0_ch   = in_char_q;
    r1_ch   = in_char_q;
    mode_nx = mode_q;
    unique case (mode_q)
      MODE_STR: begin
        n_res = 2'd1;
        if (in_char_q == CH_BSLASH && !in_last_q) begin
          mode_nx = MODE_STR_ESC;
        end else if (in_char_q == CH_QUOTE) begin
          mode_nx = MODE_NORMAL;
        end
      end
      MODE_STR_ESC: begin
        n_res   = 2'd1;
        mode_nx = MODE_STR;
      end
      MODE_SLASH: begin
        if (in_char_q == CH_SLASH) begin
          n_res   = 2'd1;
          r0_ch   = CH_SPACE;
          mode_nx = MODE_LINE;
        end else if (in_char_q == CH_STAR) begin
          n_res   = 2'd1;
          r0_ch   = CH_SPACE;
          mode_nx = MODE_BLOCK;
        end else begin
          // release the held slash ahead of this byte
          n_res   = 2'd2;
          r0_ch   = CH_SLASH;
          mode_nx = (in_char_q == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (in_char_q == CH_LF || in_char_q == CH_CR) begin
          n_res   = 2'd1;
          mode_nx = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (in_char_q == CH_STAR) begin
          mode_nx = MODE_BLOCK_STAR;
        end
      end
      MODE_BLOCK_STAR: begin
        if (in_char_q == CH_SLASH) begin
          mode_nx = MODE_NORMAL;
        end else if (in_char_q != CH_STAR) begin
          mode_nx = MODE_BLOCK;
        end
      end
      default: begin
        if (in_char_q == CH_SLASH && !in_last_q) begin
          mode_nx = MODE_SLASH;
        end else begin
          n_res   = 2'd1;
          mode_nx = (in_char_q == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
        end
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    wr_ptr_d = wr_ptr_q;
    if (fire) begin
      mode_d   = in_last_q ? MODE_NORMAL : mode_nx;
      wr_ptr_d = wr_ptr_q + BUF_AW'(n_res);
    end
    rd_ptr_d = pop ? rd_ptr_q + BUF_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (fire ? BUF_CW'(n_res) : '0) - (pop ? BUF_CW'(1) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= MODE_NORMAL;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      mode_q     <= mode_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
    end
  end

  // Input payload: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Write results; the last one of the item carries tlast.
  always_ff @(posedge clk_i) begin
    if (fire && n_res != 2'd0) begin
      buf_q[wr_ptr_q] <= '{last: (n_res == 2'd1), ch: r0_ch};
      if (n_res == 2'd2) begin
        buf_q[wr_ptr_q + BUF_AW'(1)] <= '{last: 1'b1, ch: r1_ch};
      end
    end
  end

  `ASSERT_STD(a_cnt_bound, cnt_q <= BUF_CW'(BUF_DEPTH))
  `ASSERT_STD(a_ptr_cnt, (cnt_q == '0 || cnt_q == BUF_CW'(BUF_DEPTH)) || (wr_ptr_q != rd_ptr_q))
  `ASSERT_STD(a_last_resets, fire && in_last_q |=> mode_q == MODE_NORMAL)
  `ASSERT_STD(a_held_item, in_valid_q && !fire |=> in_valid_q && $stable(in_char_q))

endmodule

`default_nettype wire

@@ dv/jcs_output_checker.sv @@
// ----------------------------------------------------------------------------
// jcs_output_checker
// Watches both streams of the comment stripper, predicts the stripped text
// from every accepted input byte and compares each output item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcs_output_checker
  import jcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_in
  input  logic       s_axis_tlast,   // is_last
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] char_out
  input  logic       m_axis_tlast,   // run_last
  output int         fail_count_o,
  output int         pending_o
);

  mode_e scan_mode;
  res_t  stripped_q[$];

  // Strip one byte: queue the bytes it releases and advance the scan mode.
  task automatic strip_byte(input logic [7:0] ch, input logic is_last);
    logic [7:0] outs[$];
    mode_e      nxt;
    nxt = scan_mode;
    case (scan_mode)
      MODE_STR: begin
        outs.insert(outs.size(), ch);
        if (ch == CH_BSLASH && !is_last) nxt = MODE_STR_ESC;
        else if (ch == CH_QUOTE) nxt = MODE_NORMAL;
      end
      MODE_STR_ESC: begin
        outs.insert(outs.size(), ch);
        nxt = MODE_STR;
      end
      MODE_SLASH: begin
        if (ch == CH_SLASH) begin
          outs.insert(outs.size(), CH_SPACE);
          nxt = MODE_LINE;
        end else if (ch == CH_STAR) begin
          outs.insert(outs.size(), CH_SPACE);
          nxt = MODE_BLOCK;
        end else begin
          // release the held slash, then handle the byte as plain text
          outs.insert(outs.size(), CH_SLASH);
          outs.insert(outs.size(), ch);
          nxt = (ch == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (ch == CH_LF || ch == CH_CR) begin
          outs.insert(outs.size(), ch);
          nxt = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (ch == CH_STAR) nxt = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (ch == CH_SLASH) nxt = MODE_NORMAL;
        else if (ch != CH_STAR) nxt = MODE_BLOCK;
      end
      default: begin
        if (ch == CH_SLASH && !is_last) begin
          nxt = MODE_SLASH;
        end else begin
          outs.insert(outs.size(), ch);
          nxt = (ch == CH_QUOTE) ? MODE_STR : MODE_NORMAL;
        end
      end
    endcase
    foreach (outs[i]) begin
      stripped_q.insert(stripped_q.size(),
                        res_t'{last: (i == outs.size() - 1), ch: outs[i]});
    end
    scan_mode = is_last ? MODE_NORMAL : nxt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    int   errs;
    errs = 0;
    if (!rst_ni) begin
      scan_mode = MODE_NORMAL;
      stripped_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (stripped_q.size() == 0) begin
          $error("unexpected item: char_out %h run_last %b", m_axis_tdata, m_axis_tlast);
          errs++;
        end else begin
          want = stripped_q.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $error("char_out mismatch: expected %h, actual %h", want.ch, m_axis_tdata);
            errs++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("run_last mismatch: expected %b, actual %b", want.last, m_axis_tlast);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) strip_byte(s_axis_tdata, s_axis_tlast);
      fail_count_o <= fail_count_o + errs;
      pending_o    <= stripped_q.size();
    end
  end

endmodule

@@ dv/tb_json_comment_stripper_unit.sv @@
// ----------------------------------------------------------------------------
// tb_json_comment_stripper_unit
// Streams directed and random JSON-with-comments texts into the stripper
// under several idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_json_comment_stripper_unit
  import jcs_pkg::*;
();

  localparam int CYCLE_LIMIT     = 400_000;
  localparam int ITEMS_PER_PHASE = 300;

  typedef enum int {
    TOK_STRING,
    TOK_LINE_CMT,
    TOK_BLOCK_CMT,
    TOK_SLASH,
    TOK_NOISE,
    TOK_PLAIN
  } tok_e;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int items_sent;
  int cycle_cnt;
  int idle_tbl[4]  = '{0, 88, 0, 17};
  int stall_tbl[4] = '{0, 0, 88, 17};

  json_comment_stripper_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  jcs_output_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_item(input logic [7:0] ch, input logic is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Send a directed text; its final byte closes the run.
  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  // Build a random text from comment, string and plain tokens, then send it.
  task automatic send_text();
    logic [7:0] txt[$];
    tok_e       tok;
    repeat ($urandom_range(1, 6)) begin
      tok = tok_e'($urandom_range(0, 5));
      case (tok)
        TOK_STRING: begin
          txt.insert(txt.size(), CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 3) == 0) txt.insert(txt.size(), CH_BSLASH);
            txt.insert(txt.size(), 8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 7) != 0) txt.insert(txt.size(), CH_QUOTE);
        end
        TOK_LINE_CMT: begin
          txt.insert(txt.size(), CH_SLASH);
          txt.insert(txt.size(), CH_SLASH);
          repeat ($urandom_range(0, 6)) begin
            txt.insert(txt.size(), 8'($urandom_range(8'h20, 8'h7E)));
          end
          txt.insert(txt.size(), $urandom_range(0, 1) ? CH_LF : CH_CR);
        end
        TOK_BLOCK_CMT: begin
          txt.insert(txt.size(), CH_SLASH);
          txt.insert(txt.size(), CH_STAR);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 3))
              0:       txt.insert(txt.size(), CH_STAR);
              1:       txt.insert(txt.size(), CH_SLASH);
              default: txt.insert(txt.size(), 8'($urandom_range(0, 255)));
            endcase
          end
          txt.insert(txt.size(), CH_STAR);
          txt.insert(txt.size(), CH_SLASH);
        end
        TOK_SLASH: begin
          txt.insert(txt.size(), CH_SLASH);
          txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
        TOK_NOISE: begin
          repeat ($urandom_range(1, 4)) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            txt.insert(txt.size(), 8'($urandom_range(8'h20, 8'h7E)));
          end
        end
      endcase
    end
    // cut some texts short so that strings and comments end unterminated
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, txt.size() - 1)) void'(txt.pop_back());
    end
    foreach (txt[i]) send_item(txt[i], i == txt.size() - 1);
  endtask

  initial begin
    int base;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    items_sent    = 0;
    cycle_cnt     = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_string("//x\n");
    send_string("/*/**/");       // opener star must not close; double star before close
    send_string("/\"\\\"\"");    // held slash releases into a string with an escape
    send_string("\"\\");         // backslash ends the text inside a string
    send_string("/");            // slash as the last byte goes out at once
    send_string("/*");           // unterminated block comment
    send_string("//\r");

    base = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tbl[ph];
      stall_pct = stall_tbl[ph];
      while (items_sent < base + (ph + 1) * ITEMS_PER_PHASE) send_text();
    end
    s_axis_tvalid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
